// ----- rtl/bea_pkg.sv -----
// ----------------------------------------------------------------------------
// bea_pkg: shared types and constants for the button edge / autorepeat core
// Key layout, repeat thresholds, register indexes and the per-key flag struct.
// ----------------------------------------------------------------------------
package bea_pkg;

	localparam int KEY_COUNT  = 21;
	localparam int OUT_WIDTH  = 23;
	localparam int BTN_WIDTH  = 12;
	localparam int AXIS_WIDTH = 8;
	localparam int CNT_WIDTH  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CNT_WIDTH-1:0] REPEAT_START = 4'd10;
	localparam logic [CNT_WIDTH-1:0] SLOW_RELOAD  = 4'd6;

	localparam int BIT_PS     = 12;
	localparam int BIT_LUP    = 13;
	localparam int BIT_LLEFT  = 15;
	localparam int BIT_RUP    = 17;
	localparam int BIT_RLEFT  = 19;
	localparam int BIT_CIRCLE = 7;
	localparam int BIT_CROSS  = 8;
	localparam int BIT_ENTER  = 21;
	localparam int BIT_CANCEL = 22;

	localparam logic [AXIS_WIDTH-1:0] CENTER_RESET    = 8'd128;
	localparam logic [AXIS_WIDTH-1:0] THRESHOLD_RESET = 8'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANALOG_CENTER    = 2'd0,
		REG_ANALOG_THRESHOLD = 2'd1,
		REG_ENTER_ON_CIRCLE  = 2'd2
	} cfg_reg_t;

	// Per-key status handed from a key lane to the top level
	typedef struct packed {
		logic prev;
		logic press;
		logic release_edge;
		logic slow;
		logic fast;
	} key_flags_t;

	// Low-side / high-side direction bits of one stick axis, signed 10-bit compare
	function automatic logic [1:0] axis_dirs(input logic [AXIS_WIDTH-1:0] sample,
			input logic [AXIS_WIDTH-1:0] center, input logic [AXIS_WIDTH-1:0] thr);
		logic signed [9:0] v;
		logic signed [9:0] lo;
		logic signed [9:0] hi;
		v  = signed'({2'b00, sample});
		lo = signed'({2'b00, center}) - signed'({2'b00, thr});
		hi = signed'({2'b00, center}) + signed'({2'b00, thr});
		if (v < lo) begin
			axis_dirs = 2'b01;
		end else if (v > hi) begin
			axis_dirs = 2'b10;
		end else begin
			axis_dirs = 2'b00;
		end
	endfunction

	// Append enter and cancel copies of cross / circle
	function automatic logic [OUT_WIDTH-1:0] add_aliases(input logic [KEY_COUNT-1:0] v,
			input logic enter_on_circle);
		logic enter;
		logic cancel;
		enter  = enter_on_circle ? v[BIT_CIRCLE] : v[BIT_CROSS];
		cancel = enter_on_circle ? v[BIT_CROSS] : v[BIT_CIRCLE];
		add_aliases = {cancel, enter, v};
	endfunction

endpackage

// ----- rtl/bea_key.sv -----
// ----------------------------------------------------------------------------
// bea_key: one key lane
// Holds the previous level and the slow / fast hold counters of one key and
// derives its edge and repeat flags for the poll in flight.
// ----------------------------------------------------------------------------
module bea_key (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                level,
	output bea_pkg::key_flags_t flags
);
	import bea_pkg::*;

	logic                 prev_q;
	logic [CNT_WIDTH-1:0] slow_cnt_q;
	logic [CNT_WIDTH-1:0] fast_cnt_q;
	logic                 slow_hit;
	logic                 fast_hit;
	logic [CNT_WIDTH-1:0] slow_base;
	logic [CNT_WIDTH-1:0] fast_base;

	always_comb begin
		slow_hit  = level && (slow_cnt_q >= REPEAT_START);
		fast_hit  = level && (fast_cnt_q >= REPEAT_START);
		slow_base = slow_hit ? SLOW_RELOAD : slow_cnt_q;
		fast_base = fast_hit ? REPEAT_START : fast_cnt_q;

		flags.prev         = prev_q;
		flags.press        = level & ~prev_q;
		flags.release_edge = ~level & prev_q;
		flags.slow         = (level & ~prev_q) | slow_hit;
		flags.fast         = (level & ~prev_q) | fast_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= 1'b0;
			slow_cnt_q <= '0;
			fast_cnt_q <= '0;
		end else if (advance) begin
			prev_q <= level;
			if (level) begin
				slow_cnt_q <= slow_base + 1'b1;
				fast_cnt_q <= fast_base + 1'b1;
			end else begin
				slow_cnt_q <= '0;
				fast_cnt_q <= '0;
			end
		end
	end

endmodule

// ----- rtl/button_edge_and_autorepeat_core.sv -----
// ----------------------------------------------------------------------------
// button_edge_and_autorepeat_core: controller poll to key events
// Maps buttons and stick axes to 21 keys and emits levels, edges and repeats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one controller poll per beat.
//   Output channel (out_valid / out_ready) carries one event beat per poll,
//   in poll order. A poll is registered on accept into the input stage,
//   evaluated against the key lanes and lands in the output register once
//   that register is empty or being drained.
//   Throughput is one poll per cycle while the receiver keeps out_ready high:
//   the input stage and the output register form a two-deep pipeline, and
//   the key lanes update as a poll moves into the output register.
//   When the receiver stalls, the output beat holds and one more poll is
//   taken into the input stage; in_ready then drops until the output drains.
//   Reset clears all previous levels and hold counters and loads center 128,
//   threshold 64 and enter on cross. Write cfg_* only while no poll is in
//   flight.
// ----------------------------------------------------------------------------
module button_edge_and_autorepeat_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bea_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bea_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [bea_pkg::BTN_WIDTH-1:0]        raw_buttons,
	input  logic                                 home_button,
	input  logic [bea_pkg::AXIS_WIDTH-1:0]       left_x,
	input  logic [bea_pkg::AXIS_WIDTH-1:0]       left_y,
	input  logic [bea_pkg::AXIS_WIDTH-1:0]       right_x,
	input  logic [bea_pkg::AXIS_WIDTH-1:0]       right_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [bea_pkg::OUT_WIDTH-1:0]        level_now,
	output logic [bea_pkg::OUT_WIDTH-1:0]        level_before,
	output logic [bea_pkg::OUT_WIDTH-1:0]        press_edges,
	output logic [bea_pkg::OUT_WIDTH-1:0]        release_edges,
	output logic [bea_pkg::OUT_WIDTH-1:0]        slow_repeat,
	output logic [bea_pkg::OUT_WIDTH-1:0]        fast_repeat
);
	import bea_pkg::*;

	logic [AXIS_WIDTH-1:0] center_q;
	logic [AXIS_WIDTH-1:0] threshold_q;
	logic                  enter_on_circle_q;

	logic                  valid_s1;
	logic [BTN_WIDTH-1:0]  buttons_s1;
	logic                  home_s1;
	logic [AXIS_WIDTH-1:0] left_x_s1;
	logic [AXIS_WIDTH-1:0] left_y_s1;
	logic [AXIS_WIDTH-1:0] right_x_s1;
	logic [AXIS_WIDTH-1:0] right_y_s1;

	logic                  advance;
	logic [KEY_COUNT-1:0]  now_keys;
	logic [KEY_COUNT-1:0]  prev_keys;
	logic [KEY_COUNT-1:0]  press_keys;
	logic [KEY_COUNT-1:0]  release_keys;
	logic [KEY_COUNT-1:0]  slow_keys;
	logic [KEY_COUNT-1:0]  fast_keys;
	key_flags_t            key_flags [KEY_COUNT];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q          <= CENTER_RESET;
			threshold_q       <= THRESHOLD_RESET;
			enter_on_circle_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANALOG_CENTER:    center_q          <= cfg_data;
				REG_ANALOG_THRESHOLD: threshold_q       <= cfg_data;
				REG_ENTER_ON_CIRCLE:  enter_on_circle_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance when a poll is in the input stage and the output register is empty or being drained
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buttons_s1 <= raw_buttons;
			home_s1    <= home_button;
			left_x_s1  <= left_x;
			left_y_s1  <= left_y;
			right_x_s1 <= right_x;
			right_y_s1 <= right_y;
		end
	end

	always_comb begin
		now_keys                        = '0;
		now_keys[BTN_WIDTH-1:0]         = buttons_s1;
		now_keys[BIT_PS]                = home_s1;
		now_keys[BIT_LUP+1:BIT_LUP]     = axis_dirs(left_y_s1, center_q, threshold_q);
		now_keys[BIT_LLEFT+1:BIT_LLEFT] = axis_dirs(left_x_s1, center_q, threshold_q);
		now_keys[BIT_RUP+1:BIT_RUP]     = axis_dirs(right_y_s1, center_q, threshold_q);
		now_keys[BIT_RLEFT+1:BIT_RLEFT] = axis_dirs(right_x_s1, center_q, threshold_q);
	end

	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
		bea_key u_key (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.level  (now_keys[k]),
			.flags  (key_flags[k])
		);
		assign prev_keys[k]    = key_flags[k].prev;
		assign press_keys[k]   = key_flags[k].press;
		assign release_keys[k] = key_flags[k].release_edge;
		assign slow_keys[k]    = key_flags[k].slow;
		assign fast_keys[k]    = key_flags[k].fast;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			level_now     <= add_aliases(now_keys, enter_on_circle_q);
			level_before  <= add_aliases(prev_keys, enter_on_circle_q);
			press_edges   <= add_aliases(press_keys, enter_on_circle_q);
			release_edges <= add_aliases(release_keys, enter_on_circle_q);
			slow_repeat   <= add_aliases(slow_keys, enter_on_circle_q);
			fast_repeat   <= add_aliases(fast_keys, enter_on_circle_q);
		end
	end

endmodule

// ----- rtl/bea_checker.sv -----
// ----------------------------------------------------------------------------
// bea_checker: port-level checks for the button edge / autorepeat core
// Watches the result channel for stalled-beat stability and event consistency.
// ----------------------------------------------------------------------------
module bea_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bea_pkg::OUT_WIDTH-1:0] level_now,
	input logic [bea_pkg::OUT_WIDTH-1:0] level_before,
	input logic [bea_pkg::OUT_WIDTH-1:0] press_edges,
	input logic [bea_pkg::OUT_WIDTH-1:0] release_edges,
	input logic [bea_pkg::OUT_WIDTH-1:0] slow_repeat,
	input logic [bea_pkg::OUT_WIDTH-1:0] fast_repeat
);
	import bea_pkg::*;

	// Stalled beat holds its level_now and slow_repeat payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_now) && $stable(slow_repeat))
		else $error("stalled result beat changed");

	// Edges agree with the two level snapshots
	a_edges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> press_edges == (level_now & ~level_before) &&
			release_edges == (level_before & ~level_now))
		else $error("edge bits disagree with levels");

	// Repeats fire only on held keys and always include the press edge
	a_repeat_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((slow_repeat | fast_repeat) & ~level_now) == '0)
		else $error("repeat on a released key");

	a_repeat_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (press_edges & ~(slow_repeat & fast_repeat)) == '0)
		else $error("press edge missing from repeat outputs");

endmodule

bind button_edge_and_autorepeat_core bea_checker u_bea_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.level_now    (level_now),
	.level_before (level_before),
	.press_edges  (press_edges),
	.release_edges(release_edges),
	.slow_repeat  (slow_repeat),
	.fast_repeat  (fast_repeat)
);
